[design/mhtq_pkg.sv]
package mhtq_pkg;

    localparam int unsigned CAPACITY_DEF  = 32;
    localparam int unsigned ID_SPACE_DEF  = 1024;
    localparam int unsigned TIME_BITS_DEF = 48;
    localparam int unsigned CMDQ_DEPTH    = 2;

    localparam int unsigned ID_W   = 10;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned WAIT_W = 32;

    localparam logic [1:0] KIND_EXPIRED   = 2'd0;
    localparam logic [1:0] KIND_CANCELLED = 2'd1;
    localparam logic [1:0] KIND_ACK       = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_ID  = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [1:0] ERR_FULL    = 2'd3;

    localparam logic [WAIT_W-1:0] WAIT_CLAMP = 32'h7fff_ffff;
    localparam logic [WAIT_W-1:0] WAIT_EMPTY = 32'hffff_ffff;

    localparam logic [2:0] ACT_ARM    = 3'd0;
    localparam logic [2:0] ACT_UPDATE = 3'd1;
    localparam logic [2:0] ACT_CANCEL = 3'd2;
    localparam logic [2:0] ACT_SVC    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ARM,
        OP_UPDATE,
        OP_CANCEL,
        OP_SERVICE,
        OP_CLEAR,
        OP_NOP,
        OP_BAD_ID
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LK_B,
        S_LK_C,
        S_SVC_A,
        S_SVC_B,
        S_RM,
        S_RM_W,
        S_SD_A,
        S_SD_B,
        S_SD_C,
        S_SU_A,
        S_SU_B,
        S_PLACE
    } bstate_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   fired_id;
        logic [WAIT_W-1:0] wait_ms;
        logic [1:0]        error_code;
        logic              last;
    } result_t;

endpackage

[design/mhtq_front.sv]
module mhtq_front
    import mhtq_pkg::*;
#(
    parameter int unsigned ID_SPACE  = ID_SPACE_DEF,
    parameter int unsigned TIME_BITS = TIME_BITS_DEF,
    localparam int unsigned CMD_W    = OP_W + ID_W + 2 * TIME_BITS
)
(
    input  logic             start,
    input  logic             q_full,
    input  logic [2:0]       action,
    input  logic [ID_W-1:0]  timer_id,
    input  logic [30:0]      timeout_ms,
    input  logic [47:0]      now_ms,
    output logic             push,
    output logic [CMD_W-1:0] cmd
);

    localparam logic [64:0] TMAX = (65'd1 << TIME_BITS) - 65'd1;

    logic [64:0] now_ext;
    logic [64:0] now_c;
    logic [64:0] sum;
    logic [64:0] exp_c;
    logic        bad_id;
    op_t         op;

    assign push    = start && !q_full;
    assign now_ext = 65'(now_ms);
    assign now_c   = (now_ext > TMAX) ? TMAX : now_ext;
    assign sum     = now_c + 65'(timeout_ms);
    assign exp_c   = (sum > TMAX) ? TMAX : sum;
    assign bad_id  = 32'(timer_id) >= ID_SPACE;

    always_comb
    begin
        unique case (action)
            ACT_ARM:    op = bad_id ? OP_BAD_ID : OP_ARM;
            ACT_UPDATE: op = bad_id ? OP_BAD_ID : OP_UPDATE;
            ACT_CANCEL: op = bad_id ? OP_BAD_ID : OP_CANCEL;
            ACT_SVC:    op = OP_SERVICE;
            ACT_CLEAR:  op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
    end

    assign cmd = {op, timer_id, exp_c[TIME_BITS-1:0], now_c[TIME_BITS-1:0]};

endmodule

[design/mhtq_cmdq.sv]
module mhtq_cmdq
    import mhtq_pkg::*;
#(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = CMDQ_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              full,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

[design/mhtq_back.sv]
module mhtq_back
    import mhtq_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned ID_SPACE  = ID_SPACE_DEF,
    parameter int unsigned TIME_BITS = TIME_BITS_DEF,
    localparam int unsigned CMD_W    = OP_W + ID_W + 2 * TIME_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] cmd,
    input  logic             q_empty,
    output logic             pop,
    output logic             res_valid,
    output result_t          res
);

    localparam int unsigned SLOT_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W  = $clog2(ID_SPACE);
    localparam int unsigned K_W    = SLOT_W + 2;

    // Heap slots and the id-to-slot map. An id is armed exactly when its
    // mapped slot lies below the entry count and that slot holds the id, so
    // the map needs no reset and a clear only zeroes the count.
    logic [TIME_BITS-1:0] hp_exp_mem [CAPACITY];
    logic [ID_W-1:0]      hp_id_mem  [CAPACITY];
    logic [SLOT_W-1:0]    slot_mem   [ID_SPACE];

    bstate_t              state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic [TIME_BITS-1:0] el_exp_reg, el_exp_next;
    logic [ID_W-1:0]      el_id_reg, el_id_next;
    logic [TIME_BITS-1:0] c0_exp_reg, c0_exp_next;
    logic [ID_W-1:0]      c0_id_reg, c0_id_next;
    logic                 moved_reg, moved_next;
    logic                 ret_svc_reg, ret_svc_next;

    logic [TIME_BITS-1:0] hp_rd_exp_reg;
    logic [ID_W-1:0]      hp_rd_id_reg;
    logic [SLOT_W-1:0]    slot_rd_reg;

    logic                 hp_re, hp_we, sl_re, sl_we;
    logic [SLOT_W-1:0]    hp_raddr, hp_waddr, sl_wdata;
    logic [TIME_BITS-1:0] hp_wexp;
    logic [ID_W-1:0]      hp_wid;
    logic [IDX_W-1:0]     sl_raddr, sl_waddr;
    logic                 emit;
    result_t              emit_res;
    logic                 res_valid_reg;
    result_t              res_reg;

    op_t                  cmd_op;
    logic [ID_W-1:0]      cmd_id;
    logic [TIME_BITS-1:0] cmd_exp, cmd_now;
    logic                 present;
    logic [K_W-1:0]       k_c, k1_c, count_k;
    logic                 k_ok, k1_ok, pick_right;
    logic [SLOT_W-1:0]    k_idx, k1_idx, parent_c, n_slot;
    logic [CNT_W-1:0]     n_c;
    logic [TIME_BITS-1:0] d_c, ch_exp;
    logic [ID_W-1:0]      ch_id;
    logic [WAIT_W-1:0]    wait_c;

    assign cmd_op  = op_t'(cmd[CMD_W-1 -: OP_W]);
    assign cmd_id  = cmd[2 * TIME_BITS +: ID_W];
    assign cmd_exp = cmd[TIME_BITS +: TIME_BITS];
    assign cmd_now = cmd[TIME_BITS-1:0];

    assign present    = (CNT_W'(pos_reg) < count_reg) && (hp_rd_id_reg == id_reg);
    assign k_c        = K_W'({pos_reg, 1'b1});
    assign k1_c       = k_c + 1'b1;
    assign count_k    = K_W'(count_reg);
    assign k_ok       = k_c < count_k;
    assign k1_ok      = k1_c < count_k;
    assign k_idx      = k_c[SLOT_W-1:0];
    assign k1_idx     = k1_c[SLOT_W-1:0];
    assign pick_right = k1_ok && (hp_rd_exp_reg < c0_exp_reg);
    assign ch_exp     = pick_right ? hp_rd_exp_reg : c0_exp_reg;
    assign ch_id      = pick_right ? hp_rd_id_reg : c0_id_reg;
    assign parent_c   = (pos_reg - 1'b1) >> 1;
    assign n_c        = count_reg - 1'b1;
    assign n_slot     = n_c[SLOT_W-1:0];
    assign d_c        = hp_rd_exp_reg - now_reg;
    assign wait_c     = (|d_c[TIME_BITS-1:31]) ? WAIT_CLAMP : WAIT_W'(d_c[30:0]);

    // Next state and datapath registers.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        exp_next     = exp_reg;
        now_next     = now_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        el_exp_next  = el_exp_reg;
        el_id_next   = el_id_reg;
        c0_exp_next  = c0_exp_reg;
        c0_id_next   = c0_id_reg;
        moved_next   = moved_reg;
        ret_svc_next = ret_svc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next    = cmd_op;
                    id_next    = cmd_id;
                    exp_next   = cmd_exp;
                    now_next   = cmd_now;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ret_svc_next = 1'b0;
                unique case (op_reg)
                    OP_ARM, OP_UPDATE, OP_CANCEL: state_next = S_LK_B;
                    OP_SERVICE:                   state_next = S_SVC_A;
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    default:                      state_next = S_IDLE;
                endcase
            end
            S_LK_B:
            begin
                pos_next   = slot_rd_reg;
                state_next = S_LK_C;
            end
            S_LK_C:
            begin
                el_exp_next = exp_reg;
                el_id_next  = id_reg;
                moved_next  = 1'b0;
                state_next  = S_IDLE;
                if (present)
                begin
                    state_next = (op_reg == OP_CANCEL) ? S_RM : S_SD_A;
                end
                else if (op_reg == OP_ARM && 32'(count_reg) < CAPACITY)
                begin
                    pos_next   = count_reg[SLOT_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_SU_A;
                end
            end
            S_SVC_A:
            begin
                state_next = (count_reg == '0) ? S_IDLE : S_SVC_B;
            end
            S_SVC_B:
            begin
                if (hp_rd_exp_reg <= now_reg)
                begin
                    pos_next     = '0;
                    ret_svc_next = 1'b1;
                    state_next   = S_RM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RM:
            begin
                count_next = n_c;
                if (CNT_W'(pos_reg) < n_c)
                begin
                    state_next = S_RM_W;
                end
                else
                begin
                    state_next = ret_svc_reg ? S_SVC_A : S_IDLE;
                end
            end
            S_RM_W:
            begin
                el_exp_next = hp_rd_exp_reg;
                el_id_next  = hp_rd_id_reg;
                moved_next  = 1'b0;
                state_next  = S_SD_A;
            end
            S_SD_A:
            begin
                if (k_ok)
                begin
                    state_next = S_SD_B;
                end
                else
                begin
                    state_next = moved_reg ? S_PLACE : S_SU_A;
                end
            end
            S_SD_B:
            begin
                c0_exp_next = hp_rd_exp_reg;
                c0_id_next  = hp_rd_id_reg;
                state_next  = S_SD_C;
            end
            S_SD_C:
            begin
                if (el_exp_reg < ch_exp)
                begin
                    state_next = moved_reg ? S_PLACE : S_SU_A;
                end
                else
                begin
                    pos_next   = pick_right ? k1_idx : k_idx;
                    moved_next = 1'b1;
                    state_next = S_SD_A;
                end
            end
            S_SU_A:
            begin
                state_next = (pos_reg == '0) ? S_PLACE : S_SU_B;
            end
            S_SU_B:
            begin
                if (hp_rd_exp_reg < el_exp_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    pos_next   = parent_c;
                    state_next = S_SU_A;
                end
            end
            S_PLACE:
            begin
                state_next = ret_svc_reg ? S_SVC_A : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory ports and result emission.
    always_comb
    begin
        pop      = 1'b0;
        hp_re    = 1'b0;
        hp_raddr = '0;
        hp_we    = 1'b0;
        hp_waddr = pos_reg;
        hp_wexp  = el_exp_reg;
        hp_wid   = el_id_reg;
        sl_re    = 1'b0;
        sl_raddr = IDX_W'(id_reg);
        sl_we    = 1'b0;
        sl_waddr = IDX_W'(el_id_reg);
        sl_wdata = pos_reg;
        emit     = 1'b0;
        emit_res = '{kind: KIND_ACK, fired_id: '0, wait_ms: '0,
                     error_code: ERR_NONE, last: 1'b1};
        unique case (state_reg)
            S_IDLE:
            begin
                pop = !q_empty;
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_ARM, OP_UPDATE, OP_CANCEL: sl_re = 1'b1;
                    OP_SERVICE:                   emit = 1'b0;
                    OP_BAD_ID:
                    begin
                        emit                = 1'b1;
                        emit_res.kind       = KIND_ERROR;
                        emit_res.error_code = ERR_BAD_ID;
                    end
                    default:                      emit = 1'b1;
                endcase
            end
            S_LK_B:
            begin
                hp_re    = 1'b1;
                hp_raddr = slot_rd_reg;
            end
            S_LK_C:
            begin
                emit = 1'b1;
                if (present)
                begin
                    if (op_reg == OP_CANCEL)
                    begin
                        emit_res.kind     = KIND_CANCELLED;
                        emit_res.fired_id = id_reg;
                    end
                end
                else if (op_reg == OP_ARM)
                begin
                    if (32'(count_reg) >= CAPACITY)
                    begin
                        emit_res.kind       = KIND_ERROR;
                        emit_res.error_code = ERR_FULL;
                    end
                end
                else
                begin
                    emit_res.kind       = KIND_ERROR;
                    emit_res.error_code = ERR_UNKNOWN;
                end
            end
            S_SVC_A:
            begin
                if (count_reg == '0)
                begin
                    emit             = 1'b1;
                    emit_res.wait_ms = WAIT_EMPTY;
                end
                else
                begin
                    hp_re = 1'b1;
                end
            end
            S_SVC_B:
            begin
                emit = 1'b1;
                if (hp_rd_exp_reg <= now_reg)
                begin
                    emit_res.kind     = KIND_EXPIRED;
                    emit_res.fired_id = hp_rd_id_reg;
                    emit_res.last     = 1'b0;
                end
                else
                begin
                    emit_res.wait_ms = wait_c;
                end
            end
            S_RM:
            begin
                hp_re    = CNT_W'(pos_reg) < n_c;
                hp_raddr = n_slot;
            end
            S_SD_A:
            begin
                hp_re    = k_ok;
                hp_raddr = k_idx;
            end
            S_SD_B:
            begin
                hp_re    = k1_ok;
                hp_raddr = k1_idx;
            end
            S_SD_C:
            begin
                if (!(el_exp_reg < ch_exp))
                begin
                    hp_we    = 1'b1;
                    hp_wexp  = ch_exp;
                    hp_wid   = ch_id;
                    sl_we    = 1'b1;
                    sl_waddr = IDX_W'(ch_id);
                end
            end
            S_SU_A:
            begin
                hp_re    = pos_reg != '0;
                hp_raddr = parent_c;
            end
            S_SU_B:
            begin
                if (!(hp_rd_exp_reg < el_exp_reg))
                begin
                    hp_we    = 1'b1;
                    hp_wexp  = hp_rd_exp_reg;
                    hp_wid   = hp_rd_id_reg;
                    sl_we    = 1'b1;
                    sl_waddr = IDX_W'(hp_rd_id_reg);
                end
            end
            S_PLACE:
            begin
                hp_we = 1'b1;
                sl_we = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            moved_reg     <= 1'b0;
            ret_svc_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= emit;
            moved_reg     <= moved_next;
            ret_svc_reg   <= ret_svc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        exp_reg    <= exp_next;
        now_reg    <= now_next;
        pos_reg    <= pos_next;
        el_exp_reg <= el_exp_next;
        el_id_reg  <= el_id_next;
        c0_exp_reg <= c0_exp_next;
        c0_id_reg  <= c0_id_next;
        res_reg    <= emit_res;
    end

    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            hp_exp_mem[hp_waddr] <= hp_wexp;
            hp_id_mem[hp_waddr]  <= hp_wid;
        end
        if (hp_re)
        begin
            hp_rd_exp_reg <= hp_exp_mem[hp_raddr];
            hp_rd_id_reg  <= hp_id_mem[hp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
        if (sl_re)
        begin
            slot_rd_reg <= slot_mem[sl_raddr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/min_heap_timer_queue.sv]
// Timer queue on a binary min-heap held in a single-port memory. A command is
// taken when start is high and busy is low; a two-entry command queue lets up
// to two commands be taken while an earlier one is still working. Results
// leave one per cycle at most, each marked by strobe for a single cycle, and
// cannot be held off. Arm, update and cancel look up the id's slot in the
// slot map, read that heap slot, then sift an entry one heap level at a time;
// unknown-id and queue-full errors end after the lookup. Service on an empty
// queue reports an empty wait; otherwise it reads the root, fires each expired
// timer by removing it from the heap, and reports the wait to the next one.
// Clear, unused actions and out-of-range ids finish without reading the heap.
module min_heap_timer_queue
    import mhtq_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned ID_SPACE  = ID_SPACE_DEF,
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [30:0]        timeout_ms,
    input  logic [47:0]        now_ms,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic [ID_W-1:0]    fired_id,
    output logic signed [31:0] wait_ms,
    output logic [1:0]         error_code,
    output logic               last
);

    localparam int unsigned CMD_W = OP_W + ID_W + 2 * TIME_BITS;

    logic             push, pop, q_full, q_empty;
    logic [CMD_W-1:0] cmd_in, cmd_out;
    result_t          res;

    mhtq_front #(
        .ID_SPACE  (ID_SPACE),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .start      (start),
        .q_full     (q_full),
        .action     (action),
        .timer_id   (timer_id),
        .timeout_ms (timeout_ms),
        .now_ms     (now_ms),
        .push       (push),
        .cmd        (cmd_in)
    );

    mhtq_cmdq #(
        .DATA_W (CMD_W),
        .DEPTH  (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .pop   (pop),
        .rdata (cmd_out),
        .full  (q_full),
        .empty (q_empty)
    );

    mhtq_back #(
        .CAPACITY  (CAPACITY),
        .ID_SPACE  (ID_SPACE),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .q_empty   (q_empty),
        .pop       (pop),
        .res_valid (strobe),
        .res       (res)
    );

    assign busy       = q_full;
    assign kind       = res.kind;
    assign fired_id   = res.fired_id;
    assign wait_ms    = res.wait_ms;
    assign error_code = res.error_code;
    assign last       = res.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_EXPIRED) |-> !last)
        else $error("expired timer reported as final result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == KIND_CANCELLED || kind == KIND_ERROR)) |-> last)
        else $error("cancel or error result not final");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_EXPIRED) |=> strobe == 1'b0)
        else $error("results emitted on consecutive cycles after a fire");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mhtq_pkg::*;

    localparam int unsigned CAP     = 32;
    localparam logic [47:0] T_MAX   = 48'hffff_ffff_ffff;

    typedef struct {
        logic [2:0]  action;
        logic [9:0]  timer_id;
        logic [30:0] timeout_ms;
        logic [47:0] now_ms;
        bit          drain;
    } timer_cmd_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] action;
    logic [ID_W-1:0] timer_id;
    logic [30:0] timeout_ms;
    logic [47:0] now_ms;
    logic strobe;
    logic [1:0] kind;
    logic [ID_W-1:0] fired_id;
    logic signed [31:0] wait_ms;
    logic [1:0] error_code;
    logic last;

    min_heap_timer_queue DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .timer_id(timer_id), .timeout_ms(timeout_ms),
        .now_ms(now_ms), .strobe(strobe), .kind(kind), .fired_id(fired_id),
        .wait_ms(wait_ms), .error_code(error_code), .last(last)
    );

    // Shadow of the timer heap.
    logic [47:0] hx_exp [CAP];
    logic [9:0]  hx_id [CAP];
    int unsigned slot_of [1024];
    bit          armed [1024];
    int unsigned fill;

    timer_cmd_t  pending_cmds[$];
    result_t     expected_results[$];
    int          errors;
    int          accepted;
    int          results_seen;
    int          fired_count;
    logic [47:0] clock_ms;
    int          gap;
    bit          held;
    bit          sent_all;
    timer_cmd_t  cur;
    bit          busy_q;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void swap_heap(int unsigned a, int unsigned b);
        logic [47:0] te;
        logic [9:0] ti;
        te = hx_exp[a];
        ti = hx_id[a];
        hx_exp[a] = hx_exp[b];
        hx_id[a] = hx_id[b];
        hx_exp[b] = te;
        hx_id[b] = ti;
        slot_of[hx_id[a]] = a;
        slot_of[hx_id[b]] = b;
    endfunction

    function automatic void bubble_up(int unsigned i);
        int unsigned p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (hx_exp[p] < hx_exp[i])
                break;
            swap_heap(p, i);
            i = p;
        end
    endfunction

    function automatic bit bubble_down(int unsigned i, int unsigned n);
        int unsigned j;
        int unsigned k;
        j = i;
        k = 2 * j + 1;
        while (k < n)
        begin
            if (k + 1 < n && hx_exp[k + 1] < hx_exp[k])
                k++;
            if (hx_exp[j] < hx_exp[k])
                break;
            swap_heap(j, k);
            j = k;
            k = 2 * j + 1;
        end
        return j > i;
    endfunction

    function automatic void drop_slot(int unsigned i);
        int unsigned n;
        if (i >= fill)
            return;
        n = fill - 1;
        if (i < n)
        begin
            swap_heap(i, n);
            if (!bubble_down(i, n))
                bubble_up(i);
        end
        armed[hx_id[n]] = 1'b0;
        fill = n;
    endfunction

    function automatic void push_result(logic [1:0] k, logic [9:0] id,
                                        logic [31:0] w, logic [1:0] e);
        result_t r;
        r.kind = k;
        r.fired_id = id;
        r.wait_ms = w;
        r.error_code = e;
        r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_timer_results(timer_cmd_t c);
        logic [47:0] expiry;
        logic [47:0] d;
        logic [31:0] w;
        int unsigned s;
        expiry = (T_MAX - c.now_ms < {17'd0, c.timeout_ms}) ? T_MAX
                 : c.now_ms + {17'd0, c.timeout_ms};
        if (c.action == ACT_ARM)
        begin
            if (armed[c.timer_id])
            begin
                s = slot_of[c.timer_id];
                hx_exp[s] = expiry;
                if (!bubble_down(s, fill))
                    bubble_up(s);
                push_result(KIND_ACK, '0, '0, ERR_NONE);
            end
            else if (fill >= CAP)
                push_result(KIND_ERROR, '0, '0, ERR_FULL);
            else
            begin
                s = fill;
                hx_exp[s] = expiry;
                hx_id[s] = c.timer_id;
                slot_of[c.timer_id] = s;
                armed[c.timer_id] = 1'b1;
                fill++;
                bubble_up(s);
                push_result(KIND_ACK, '0, '0, ERR_NONE);
            end
        end
        else if (c.action == ACT_UPDATE || c.action == ACT_CANCEL)
        begin
            if (fill == 0 || !armed[c.timer_id])
                push_result(KIND_ERROR, '0, '0, ERR_UNKNOWN);
            else if (c.action == ACT_UPDATE)
            begin
                s = slot_of[c.timer_id];
                hx_exp[s] = expiry;
                if (!bubble_down(s, fill))
                    bubble_up(s);
                push_result(KIND_ACK, '0, '0, ERR_NONE);
            end
            else
            begin
                push_result(KIND_CANCELLED, c.timer_id, '0, ERR_NONE);
                drop_slot(slot_of[c.timer_id]);
            end
        end
        else if (c.action == ACT_SVC)
        begin
            w = WAIT_EMPTY;
            while (fill > 0 && hx_exp[0] <= c.now_ms)
            begin
                push_result(KIND_EXPIRED, hx_id[0], '0, ERR_NONE);
                drop_slot(0);
            end
            if (fill > 0)
            begin
                d = hx_exp[0] - c.now_ms;
                w = (d > 48'(WAIT_CLAMP)) ? WAIT_CLAMP : d[31:0];
            end
            push_result(KIND_ACK, '0, w, ERR_NONE);
        end
        else
        begin
            if (c.action == ACT_CLEAR)
            begin
                foreach (armed[i])
                    armed[i] = 1'b0;
                fill = 0;
            end
            push_result(KIND_ACK, '0, '0, ERR_NONE);
        end
        expected_results[$].last = 1'b1;
    endfunction

    function automatic void queue_cmd(logic [2:0] a, logic [9:0] id,
                                      logic [30:0] t, logic [47:0] adv);
        timer_cmd_t c;
        clock_ms = (T_MAX - clock_ms < adv) ? T_MAX : clock_ms + adv;
        c.action = a;
        c.timer_id = id;
        c.timeout_ms = t;
        c.now_ms = clock_ms;
        c.drain = 1'b0;
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Driver: one transaction per command, with a random gap before each.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !held)
            begin
                if (!busy_q)
                begin
                    predict_timer_results(cur);
                    accepted++;
                    pending_cmds.pop_front();
                    gap = $urandom_range(0, 5);
                    if ($urandom_range(0, 2) == 0)
                        gap = 0;
                end
            end
            if (pending_cmds.size() == 0)
            begin
                start <= 1'b0;
                sent_all = 1'b1;
            end
            else if (gap > 0)
            begin
                start <= 1'b0;
                gap--;
            end
            else if (pending_cmds[0].drain)
            begin
                start <= 1'b0;
                if (expected_results.size() == 0)
                    pending_cmds.pop_front();
            end
            else
            begin
                cur = pending_cmds[0];
                start <= 1'b1;
                action <= cur.action;
                timer_id <= cur.timer_id;
                timeout_ms <= cur.timeout_ms;
                now_ms <= cur.now_ms;
            end
            held = 1'b0;
        end
    end

    // Acceptance is decided at the rising edge; the driver reads it afterwards.
    always @(posedge clk)
        busy_q <= busy || !start;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual kind=%0d id=%0d",
                         $time, kind, fired_id);
            end
            else
            begin
                if (kind == KIND_EXPIRED)
                    fired_count++;
                if (kind !== expected_results[0].kind
                    || fired_id !== expected_results[0].fired_id
                    || wait_ms !== expected_results[0].wait_ms
                    || error_code !== expected_results[0].error_code
                    || last !== expected_results[0].last)
                begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d id=%0d wait=%0d err=%0d last=%0d",
                             $time, expected_results[0].kind, expected_results[0].fired_id,
                             $signed(expected_results[0].wait_ms),
                             expected_results[0].error_code, expected_results[0].last);
                    $display("%0t:          actual   kind=%0d id=%0d wait=%0d err=%0d last=%0d",
                             $time, kind, fired_id, wait_ms, error_code, last);
                end
                expected_results.pop_front();
            end
        end
    end

    initial
    begin
        int n;
        int unsigned r;
        logic [2:0] a;
        rst_n = 1'b0;
        start = 1'b0;
        action = '0;
        timer_id = '0;
        timeout_ms = '0;
        now_ms = '0;
        errors = 0;
        accepted = 0;
        results_seen = 0;
        fired_count = 0;
        clock_ms = '0;
        gap = 0;
        held = 1'b0;
        busy_q = 1'b1;
        sent_all = 1'b0;
        fill = 0;
        foreach (armed[i])
            armed[i] = 1'b0;

        // Directed: empty-queue errors and service, extremes, ties, capacity.
        queue_cmd(ACT_SVC, 0, 0, 0);
        queue_cmd(ACT_UPDATE, 10'd5, 31'd7, 0);
        queue_cmd(ACT_CANCEL, 10'h3ff, 0, 0);
        queue_cmd(ACT_ARM, 10'h3ff, 31'h7fff_ffff, 1);
        queue_cmd(ACT_ARM, 10'd0, 31'd0, 0);
        queue_cmd(ACT_ARM, 10'd1, 31'd0, 0);
        queue_cmd(ACT_ARM, 10'd2, 31'd10, 0);
        queue_cmd(ACT_UPDATE, 10'd2, 31'd0, 0);
        queue_cmd(ACT_ARM, 10'd0, 31'd50, 0);
        queue_cmd(ACT_CANCEL, 10'd1, 0, 0);
        queue_cmd(ACT_SVC, 0, 0, 5);
        queue_cmd(3'd5, 10'h2aa, 31'h5555_5555, 0);
        queue_cmd(3'd7, 10'h155, 31'h2aaa_aaaa, 0);
        for (int i = 0; i < 33; i++)
            queue_cmd(ACT_ARM, 10'(i + 100), 31'(i % 3), 0);
        queue_cmd(ACT_SVC, 0, 0, 2);
        queue_cmd(ACT_CLEAR, 0, 0, 0);
        queue_cmd(ACT_CANCEL, 10'd100, 0, 0);
        queue_cmd(ACT_ARM, 10'd9, 31'h7fff_ffff, 48'hffff_ffff_fff0);
        queue_cmd(ACT_SVC, 0, 0, 48'hffff_ffff_ffff);
        queue_cmd(ACT_SVC, 0, 0, 0);
        queue_cmd(ACT_CLEAR, 0, 0, 0);
        // The directed part drove time to its ceiling; restart from zero.
        begin
            timer_cmd_t h;
            h.drain = 1'b1;
            pending_cmds.insert(pending_cmds.size(), h);
        end
        clock_ms = '0;
        rst_n = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the first batch is out, then restart time after a clear.
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        clock_ms = '0;
        queue_cmd(ACT_CLEAR, 0, 0, 0);
        sent_all = 1'b0;

        // Random: mostly arms over a small id pool with short timeouts, plus
        // services that fire them; occasional wide values and noise.
        n = 0;
        while (n < 150)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                a = ACT_ARM;
            else if (r < 55)
                a = ACT_UPDATE;
            else if (r < 67)
                a = ACT_CANCEL;
            else if (r < 92)
                a = ACT_SVC;
            else if (r < 95)
                a = ACT_CLEAR;
            else
                a = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) == 0)
                queue_cmd(a, 10'($urandom), 31'($urandom), 48'($urandom_range(0, 3)));
            else
                queue_cmd(a, 10'($urandom_range(0, 40)), 31'($urandom_range(0, 60)),
                          48'($urandom_range(0, 12)));
            if (n == 100)
            begin
                timer_cmd_t h;
                h.drain = 1'b1;
                pending_cmds.insert(pending_cmds.size(), h);
            end
            n++;
        end
        queue_cmd(ACT_ARM, 10'h3ff, 31'h7fff_ffff, 48'hffff_ffff_ffff);
        queue_cmd(ACT_SVC, 0, 0, 0);

        wait (sent_all && pending_cmds.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("Accepted %0d commands, checked %0d results, %0d timers fired by service.",
                 accepted, results_seen, fired_count);
        if (errors == 0)
            $display("min_heap_timer_queue verification clean");
        else
            $display("min_heap_timer_queue verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("min_heap_timer_queue verification failed");
        $finish;
    end

endmodule
